// File: sv/calu_pkg.sv
`timescale 1ns / 1ps

package calu_pkg;

  // Datapath geometry.
  localparam int unsigned DataWidth  = 64;
  localparam int unsigned HalfWidth  = DataWidth / 2;
  localparam int unsigned ShiftWidth = $clog2(DataWidth);
  localparam int unsigned FeatWidth  = 8;
  localparam int unsigned CmdWidth   = 5;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
  localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);
  localparam int unsigned DivStages  = DataWidth;

  // Operation codes as they arrive on the command field.
  localparam logic [CmdWidth-1:0] CmdInc = 5'h00;
  localparam logic [CmdWidth-1:0] CmdDec = 5'h01;
  localparam logic [CmdWidth-1:0] CmdNeg = 5'h02;
  localparam logic [CmdWidth-1:0] CmdNot = 5'h03;
  localparam logic [CmdWidth-1:0] CmdAdd = 5'h10;
  localparam logic [CmdWidth-1:0] CmdSub = 5'h11;
  localparam logic [CmdWidth-1:0] CmdMul = 5'h12;
  localparam logic [CmdWidth-1:0] CmdDiv = 5'h13;
  localparam logic [CmdWidth-1:0] CmdAnd = 5'h14;
  localparam logic [CmdWidth-1:0] CmdOr  = 5'h15;
  localparam logic [CmdWidth-1:0] CmdXor = 5'h16;
  localparam logic [CmdWidth-1:0] CmdCmp = 5'h17;
  localparam logic [CmdWidth-1:0] CmdLsh = 5'h1C;
  localparam logic [CmdWidth-1:0] CmdRsh = 5'h1D;
  localparam logic [CmdWidth-1:0] CmdRas = 5'h1E;

  // Class flags of the status byte.
  localparam logic [FeatWidth-1:0] FlagNeg  = 8'h01;
  localparam logic [FeatWidth-1:0] FlagPos  = 8'h02;
  localparam logic [FeatWidth-1:0] FlagZero = 8'h04;

  // Decoded operation.
  typedef enum logic [3:0] {
    OpPass, OpInc, OpDec, OpNeg, OpNot, OpAdd, OpSub, OpMul,
    OpDiv, OpAnd, OpOr, OpXor, OpLsh, OpRsh, OpRas
  } op_e;

  // One queued operation.
  typedef struct packed {
    op_e                  op;
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  vld;
    item_t item;
  } head_t;

  // Payload carried down the execute pipeline.
  typedef struct packed {
    op_e                  op;
    logic [DataWidth-1:0] res;
    logic                 neg;
    logic                 dz;
    logic [DataWidth:0]   rem;
    logic [DataWidth-1:0] dq;
    logic [DataWidth-1:0] dvs;
    logic [DataWidth-1:0] pll;
    logic [HalfWidth-1:0] plh;
    logic [HalfWidth-1:0] phl;
  } stage_t;

  // Map a command code to an operation; unassigned codes pass a through.
  function automatic op_e classify(logic [CmdWidth-1:0] cmd);
    op_e op;
    case (cmd)
      CmdInc:         op = OpInc;
      CmdDec:         op = OpDec;
      CmdNeg:         op = OpNeg;
      CmdNot:         op = OpNot;
      CmdAdd:         op = OpAdd;
      CmdSub, CmdCmp: op = OpSub;
      CmdMul:         op = OpMul;
      CmdDiv:         op = OpDiv;
      CmdAnd:         op = OpAnd;
      CmdOr:          op = OpOr;
      CmdXor:         op = OpXor;
      CmdLsh:         op = OpLsh;
      CmdRsh:         op = OpRsh;
      CmdRas:         op = OpRas;
      default:        op = OpPass;
    endcase
    return op;
  endfunction

endpackage

// File: sv/cpu_alu_with_flags_top.sv
`timescale 1ns / 1ps
// 64-bit ALU with status flags.
// Input channel: in_valid_i/in_ready_o carry one beat of cmd_i, operand_a_i
// and operand_b_i. Output channel: out_valid_o/out_ready_i carry one beat of
// result_o and status_byte_o for every input beat, in order.
// The front end decodes the command into a two-entry queue. The back end is
// a 66-stage pipeline: an entry stage, 64 divider stages of one quotient bit
// each, and the output register. Throughput is one beat per cycle while the
// receiver holds out_ready_i high, set by the one-bit-per-stage divider and
// the split 32-bit multiplier.
// When the receiver stalls, the whole back end holds; the queue takes beats
// until both of its entries are full, and then in_ready_o drops.
// Reset empties the queue and pipeline and clears the feature bits.
// cfg_we_i writes cfg_wdata_i into the feature bits, which are ORed into
// every status byte; write them only while the block is idle.

module cpu_alu_with_flags_top
  import calu_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [FeatWidth-1:0]        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [CmdWidth-1:0]         cmd_i,
  input  logic signed [DataWidth-1:0] operand_a_i,
  input  logic signed [DataWidth-1:0] operand_b_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DataWidth-1:0] result_o,
  output logic [FeatWidth-1:0]        status_byte_o
);

  logic [FeatWidth-1:0] feature_q;
  head_t                head;
  logic                 pop;
  logic [DataWidth-1:0] res;

  // Feature bits register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feature_q <= '0;
    end else if (cfg_we_i) begin
      feature_q <= cfg_wdata_i;
    end
  end

  calu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .head_o      (head),
    .pop_i       (pop)
  );

  calu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .feature_i   (feature_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (res),
    .status_o    (status_byte_o)
  );

  assign result_o = $signed(res);

  // Exactly one class flag when no feature bit overlaps them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (feature_q[2:0] == 3'b000) |-> $onehot(status_byte_o[2:0]))
    else $error("status class flags not one-hot");

  // A zero result reports the zero flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_o == '0) |-> status_byte_o[2])
    else $error("zero result without zero flag");

  // A negative result reports the negative flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_o[DataWidth-1] |-> status_byte_o[0])
    else $error("negative result without negative flag");

endmodule

// File: sv/calu_front.sv
`timescale 1ns / 1ps

module calu_front
  import calu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CmdWidth-1:0]  cmd_i,
  input  logic [DataWidth-1:0] operand_a_i,
  input  logic [DataWidth-1:0] operand_b_i,
  output head_t                head_o,
  input  logic                 pop_i
);

  item_t                mem_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntWidth-1:0] cnt_q;
  logic                 push;
  logic                 pop;

  // Accept a beat whenever the queue has room.
  assign in_ready_o = (cnt_q != QCntWidth'(QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && head_o.vld;

  assign head_o.vld  = (cnt_q != '0);
  assign head_o.item = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the decoded operation with its operands.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{op: classify(cmd_i), a: operand_a_i, b: operand_b_i};
    end
  end

endmodule

// File: sv/calu_back.sv
`timescale 1ns / 1ps

module calu_back
  import calu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  head_t                head_i,
  output logic                 pop_o,
  input  logic [FeatWidth-1:0] feature_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DataWidth-1:0] result_o,
  output logic [FeatWidth-1:0] status_o
);

  logic                  adv;
  logic                  vld_q [DivStages+1];
  stage_t                stg_q [DivStages+1];
  stage_t                stg_d [DivStages+1];
  logic                  out_vld_q;
  logic [DataWidth-1:0]  res_q;
  logic [FeatWidth-1:0]  stat_q;
  logic [DataWidth-1:0]  fin_res;
  logic [FeatWidth-1:0]  fin_stat;

  // The whole pipeline moves when the output register can take a beat.
  assign adv   = !out_vld_q || out_ready_i;
  assign pop_o = adv;

  // Entry stage: simple operations, partial products, divider setup.
  always_comb begin
    logic [DataWidth-1:0]  a, b;
    logic [ShiftWidth-1:0] n;
    a = head_i.item.a;
    b = head_i.item.b;
    n = b[ShiftWidth-1:0];
    stg_d[0].op  = head_i.item.op;
    case (head_i.item.op)
      OpInc:   stg_d[0].res = a + 1'b1;
      OpDec:   stg_d[0].res = a - 1'b1;
      OpNeg:   stg_d[0].res = '0 - a;
      OpNot:   stg_d[0].res = ~a;
      OpAdd:   stg_d[0].res = a + b;
      OpSub:   stg_d[0].res = a - b;
      OpAnd:   stg_d[0].res = a & b;
      OpOr:    stg_d[0].res = a | b;
      OpXor:   stg_d[0].res = a ^ b;
      OpLsh:   stg_d[0].res = a << n;
      OpRsh:   stg_d[0].res = a >> n;
      OpRas:   stg_d[0].res = $unsigned($signed(a) >>> n);
      default: stg_d[0].res = a;
    endcase
    stg_d[0].neg = a[DataWidth-1] ^ b[DataWidth-1];
    stg_d[0].dz  = (b == '0);
    stg_d[0].rem = '0;
    stg_d[0].dq  = a[DataWidth-1] ? '0 - a : a;
    stg_d[0].dvs = b[DataWidth-1] ? '0 - b : b;
    stg_d[0].pll = DataWidth'(a[HalfWidth-1:0] * b[HalfWidth-1:0]);
    stg_d[0].plh = HalfWidth'(a[HalfWidth-1:0] * b[DataWidth-1:HalfWidth]);
    stg_d[0].phl = HalfWidth'(a[DataWidth-1:HalfWidth] * b[HalfWidth-1:0]);
  end

  // Restoring divider: one quotient bit per stage.
  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    always_comb begin
      logic [DataWidth:0] r_sh;
      logic [DataWidth:0] diff;
      r_sh = {stg_q[k-1].rem[DataWidth-1:0], stg_q[k-1].dq[DataWidth-1]};
      diff = r_sh - {1'b0, stg_q[k-1].dvs};
      stg_d[k] = stg_q[k-1];
      if (!diff[DataWidth]) begin
        stg_d[k].rem = diff;
        stg_d[k].dq  = {stg_q[k-1].dq[DataWidth-2:0], 1'b1};
      end else begin
        stg_d[k].rem = r_sh;
        stg_d[k].dq  = {stg_q[k-1].dq[DataWidth-2:0], 1'b0};
      end
    end
  end

  for (genvar k = 0; k <= DivStages; k++) begin : g_stg
    // Valid bits of the pipeline.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= (k == 0) ? head_i.vld : vld_q[(k == 0) ? 0 : k-1];
      end
    end

    // Stage payload.
    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // Final selection and classification of the result.
  always_comb begin
    stage_t s;
    s = stg_q[DivStages];
    case (s.op)
      OpMul:   fin_res = s.pll + {s.plh + s.phl, {HalfWidth{1'b0}}};
      OpDiv:   fin_res = s.dz ? '0 : (s.neg ? '0 - s.dq : s.dq);
      default: fin_res = s.res;
    endcase
    if (fin_res == '0) begin
      fin_stat = feature_i | FlagZero;
    end else if (fin_res[DataWidth-1]) begin
      fin_stat = feature_i | FlagNeg;
    end else begin
      fin_stat = feature_i | FlagPos;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q  <= fin_res;
      stat_q <= fin_stat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;
  assign status_o    = stat_q;

endmodule
